>>> src/pip_pkg.sv
// shared types and constants for the point-in-polygon test
package pip_pkg;

  localparam int unsigned MaxVertices = 16;
  localparam int unsigned CfgWidth   = 5;
  localparam int unsigned SlotWidth  = 4;
  localparam logic [CfgWidth-1:0] CfgResetCount = 5'd4;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef struct packed {
    logic write;   // store a vertex from the request
    logic load;    // capture test point and start a walk
    logic issue;   // launch the current edge into the pipeline
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;      // polygon has no vertices
    logic last_issue;  // current edge is the last one
    logic pipe_busy;   // edges still in flight
  } dp_status_t;

endpackage

>>> src/pip_ctrl.sv
// controller state machine for the point-in-polygon test
module pip_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               func_i,
  input  pip_pkg::dp_status_t status_i,
  output pip_pkg::dp_cmd_t    cmd_o,
  output logic               busy,
  output logic               done_o
);
  import pip_pkg::*;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StWalk  = 4'b0010,
    StDrain = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    busy        = 1'b1;
    done_o      = 1'b0;
    case (state_q)
      StIdle: begin
        busy = 1'b0;
        if (start) begin
          if (func_i == FuncQuery) begin
            cmd_o.load = 1'b1;
            state_d    = status_i.n_zero ? StDrain : StWalk;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      StWalk: begin
        cmd_o.issue = 1'b1;
        if (status_i.last_issue) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!status_i.pipe_busy) begin
          state_d = StDone;
        end
      end
      StDone: begin
        done_o  = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

>>> src/pip_datapath.sv
// vertex store and edge crossing pipeline for the point-in-polygon test
module pip_datapath #(
  parameter int unsigned COORD_WIDTH  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pip_pkg::dp_cmd_t                   cmd_i,
  output pip_pkg::dp_status_t                status_o,
  input  logic                               cfg_we_i,
  input  logic [pip_pkg::CfgWidth-1:0]       cfg_wdata_i,
  input  logic [pip_pkg::SlotWidth-1:0]      slot_i,
  input  logic signed [COORD_WIDTH-1:0]      coord_x_i,
  input  logic signed [COORD_WIDTH-1:0]      coord_y_i,
  output logic                               parity_o
);
  import pip_pkg::*;

  localparam int unsigned IW = $clog2(MaxVertices);
  localparam int unsigned CW = $clog2(MaxVertices + 1);
  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;

  // vertex store, two read ports with registered data
  logic signed [COORD_WIDTH-1:0] mem_x [MaxVertices];
  logic signed [COORD_WIDTH-1:0] mem_y [MaxVertices];

  logic [CfgWidth-1:0] cfg_q;
  logic [CW-1:0]       n_sat, n_q;
  logic [IW-1:0]       idx_q, jdx;
  logic signed [COORD_WIDTH-1:0] tx_q, ty_q;
  logic signed [COORD_WIDTH-1:0] xi_q, yi_q, xj_q, yj_q;
  logic                v1_q, v2_q, v3_q, neg2_q, neg3_q, parity_q;
  logic signed [DW-1:0] a_q, b_q, c_q, d_q;
  logic signed [PW-1:0] p_q, q_q;
  logic                straddle, hit;

  assign n_sat = (32'(cfg_q) > 32'(MaxVertices)) ? CW'(MaxVertices) : CW'(cfg_q);
  assign jdx   = (idx_q == '0) ? IW'(n_q - CW'(1)) : idx_q - IW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && (32'(slot_i) < 32'(MaxVertices))) begin
      mem_x[IW'(slot_i)] <= coord_x_i;
      mem_y[IW'(slot_i)] <= coord_y_i;
    end
    xi_q <= mem_x[idx_q];
    yi_q <= mem_y[idx_q];
    xj_q <= mem_x[jdx];
    yj_q <= mem_y[jdx];
  end

  assign straddle = (yi_q > ty_q) != (yj_q > ty_q);

  // payload stages
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tx_q <= coord_x_i;
      ty_q <= coord_y_i;
    end
    a_q    <= DW'(tx_q) - DW'(xi_q);
    b_q    <= DW'(yj_q) - DW'(yi_q);
    c_q    <= DW'(xj_q) - DW'(xi_q);
    d_q    <= DW'(ty_q) - DW'(yi_q);
    neg2_q <= yj_q < yi_q;
    p_q    <= a_q * b_q;
    q_q    <= c_q * d_q;
    neg3_q <= neg2_q;
  end

  // crossing lies right of the test point, direction set by the edge's y span
  assign hit = v3_q && (neg3_q ? (p_q > q_q) : (p_q < q_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= CfgResetCount;
      n_q      <= '0;
      idx_q    <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      parity_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        n_q      <= n_sat;
        idx_q    <= '0;
        parity_q <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          idx_q <= idx_q + IW'(1);
        end
        if (hit) begin
          parity_q <= ~parity_q;
        end
      end
      v1_q <= cmd_i.issue;
      v2_q <= v1_q && straddle;
      v3_q <= v2_q;
    end
  end

  assign status_o.n_zero     = (n_sat == '0);
  assign status_o.last_issue = (CW'(idx_q) == n_q - CW'(1));
  assign status_o.pipe_busy  = v1_q | v2_q | v3_q;
  assign parity_o            = parity_q;

endmodule

>>> src/point_in_polygon_test.sv
// point-in-polygon test by crossing number, top level
// a vertex write request gives no result and leaves the block idle
// a query over n vertices walks the edges, drains the pipeline, then gives its result (no walk when n is 0)
// busy stays high until the result cycle ends, so a new query is taken only after the last result
// the edge walk issues one edge per cycle through one compare pipeline
// async active-low reset sets vertex_count to 4; vertex store is not cleared
module point_in_polygon_test #(
  parameter int unsigned COORD_WIDTH  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request side
  input  logic                          start,
  output logic                          busy,
  input  logic                          func_i,
  input  logic [pip_pkg::SlotWidth-1:0] slot_i,
  input  logic signed [COORD_WIDTH-1:0] coord_x_i,
  input  logic signed [COORD_WIDTH-1:0] coord_y_i,
  // vertex_count register
  input  logic                          cfg_we_i,
  input  logic [pip_pkg::CfgWidth-1:0]  cfg_wdata_i,
  // result side, one cycle strobe, cannot be stalled
  output logic                          done_o,
  output logic                          inside_res_o
);
  import pip_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       parity;

  // controller: idle, walk edges, drain the pipeline, present the result
  pip_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .func_i   (func_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  // datapath: vertex store read at edge ends i and i-1 (wrapping), then
  // differences, two cross products and a signed compare that flips the parity
  pip_datapath #(
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .slot_i      (slot_i),
    .coord_x_i   (coord_x_i),
    .coord_y_i   (coord_y_i),
    .parity_o    (parity)
  );

  // parity is settled once the pipeline has drained
  assign inside_res_o = parity;

endmodule

>>> bench/testbench.sv
// self-checking bench for the crossing-number point-in-polygon block
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import pip_pkg::*;

  localparam int unsigned MaxCorners   = 16;
  localparam int unsigned CoordBits    = 16;
  localparam int unsigned NumDirected  = 24;
  localparam int unsigned NumPhases    = 12;
  localparam int unsigned PhaseItems   = 150;
  // a short pause lets the last vertex write settle before a register write
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned DrainCycles  = 8;

  typedef logic signed [CoordBits-1:0] coord_t;

  // how vertex and test point coordinates are drawn
  typedef enum logic [1:0] {
    ShapeWide,   // anywhere in the full signed range
    ShapeTight,  // within 48 units of the origin, so points land on vertices and edges
    ShapeEdge,   // only the range limits, zero and minus one
    ShapeMixed   // each coordinate picks one of the above
  } shape_e;

  // one row of the directed table; a typed-in answer is used where has_answer is set
  typedef struct packed {
    logic                 func;
    logic [SlotWidth-1:0] slot;
    coord_t               x;
    coord_t               y;
    logic                 has_answer;
    logic                 answer;
  } dir_row_t;

  // clock, reset and block inputs, all known from time zero
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start       = 1'b0;
  logic                 func_i      = FuncWrite;
  logic [SlotWidth-1:0] slot_i      = '0;
  coord_t               coord_x_i   = '0;
  coord_t               coord_y_i   = '0;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgWidth-1:0]  cfg_wdata_i = '0;
  logic                 busy;
  logic                 done_o;
  logic                 inside_res_o;

  // sideband that travels with each request: a fixed answer from the directed table
  logic                 answer_given = 1'b0;
  logic                 answer_value = 1'b0;

  // predictor state: the polygon as the block should hold it, and the vertex count
  coord_t               corner_x [MaxCorners];
  coord_t               corner_y [MaxCorners];
  logic [CfgWidth-1:0]  poly_count = CfgResetCount;
  logic                 inside_due [$];
  logic                 inside_want;
  int unsigned          fail_count = 0;

  // stimulus bookkeeping
  logic [MaxCorners-1:0] slot_written = '0;
  int unsigned           idle_pct     = 12;
  int unsigned           phase_items  = 0;
  int unsigned           live_corners;
  shape_e                shape_mode   = ShapeTight;

  // directed part, run with the vertex count left at its reset value of four
  dir_row_t directed_rows [NumDirected] = '{
    // a 320 by 320 square centered on the origin
    '{FuncWrite, 4'd0, -16'sd160, -16'sd160, 1'b0, 1'b0},
    '{FuncWrite, 4'd1,  16'sd160, -16'sd160, 1'b0, 1'b0},
    '{FuncWrite, 4'd2,  16'sd160,  16'sd160, 1'b0, 1'b0},
    '{FuncWrite, 4'd3, -16'sd160,  16'sd160, 1'b0, 1'b0},
    // center is inside, far points on every side are outside
    '{FuncQuery, 4'hf,  16'sd0,       16'sd0,      1'b1, 1'b1},
    '{FuncQuery, 4'h0,  16'sd32767,   16'sd0,      1'b1, 1'b0},
    '{FuncQuery, 4'ha,  16'sh8000,    16'sd0,      1'b1, 1'b0},
    '{FuncQuery, 4'h5,  16'sd0,       16'sd32767,  1'b1, 1'b0},
    '{FuncQuery, 4'h3,  16'sd0,       16'sh8000,   1'b1, 1'b0},
    // on the top edge, on the left edge, on a corner: left to the predictor
    '{FuncQuery, 4'hc,  16'sd0,       16'sd160,    1'b0, 1'b0},
    '{FuncQuery, 4'h1, -16'sd160,     16'sd0,      1'b0, 1'b0},
    '{FuncQuery, 4'h7,  16'sd160,    -16'sd160,    1'b0, 1'b0},
    // the largest square the coordinates allow, widest products in the compare
    '{FuncWrite, 4'd0,  16'sh8000,    16'sh8000,   1'b0, 1'b0},
    '{FuncWrite, 4'd1,  16'sd32767,   16'sh8000,   1'b0, 1'b0},
    '{FuncWrite, 4'd2,  16'sd32767,   16'sd32767,  1'b0, 1'b0},
    '{FuncWrite, 4'd3,  16'sh8000,    16'sd32767,  1'b0, 1'b0},
    '{FuncQuery, 4'h9,  16'sd0,       16'sd0,      1'b1, 1'b1},
    '{FuncQuery, 4'h6, -16'sd1,      -16'sd1,      1'b1, 1'b1},
    '{FuncQuery, 4'h2,  16'sh8000,    16'sd0,      1'b0, 1'b0},
    '{FuncQuery, 4'hd,  16'sd32767,   16'sd32767,  1'b0, 1'b0},
    '{FuncQuery, 4'h4,  16'sd32767,   16'sh8000,   1'b0, 1'b0},
    '{FuncQuery, 4'hb,  16'sd1,       16'sh8000,   1'b0, 1'b0},
    '{FuncQuery, 4'he,  16'sd32767,   16'sd1,      1'b0, 1'b0},
    '{FuncQuery, 4'h8, -16'sd32767,  -16'sd32767,  1'b0, 1'b0}
  };

  // vertex counts per random phase: reset value, both range limits and the
  // degenerate and saturating values outside the meaningful range
  logic [CfgWidth-1:0] phase_count [NumPhases] = '{
    5'd3, 5'd16, 5'd31, 5'd0, 5'd5, 5'd2, 5'd17, 5'd1, 5'd9, 5'd16, 5'd4, 5'd12
  };

  point_in_polygon_test i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .slot_i       (slot_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .inside_res_o (inside_res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // vertex count a query really walks: anything above the store depth saturates
  function automatic int unsigned walked_corners(logic [CfgWidth-1:0] count);
    return (count > MaxCorners) ? MaxCorners : int'(count);
  endfunction

  // even-odd crossing count with an exact cross-multiplied intersection test;
  // coordinates are at most 17 bits after subtraction, so products fit in 64
  function automatic logic odd_crossings(longint tx, longint ty);
    int unsigned n;
    int unsigned j;
    longint      xi, yi, xj, yj, dy, lhs, rhs;
    logic        parity;
    n      = walked_corners(poly_count);
    parity = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      j  = (i == 0) ? n - 1 : i - 1;
      xi = corner_x[i];
      yi = corner_y[i];
      xj = corner_x[j];
      yj = corner_y[j];
      // an edge only counts if its ends lie on opposite sides of the test y;
      // a flat edge never does
      if ((yi > ty) != (yj > ty)) begin
        dy  = yj - yi;
        lhs = (tx - xi) * dy;
        rhs = (xj - xi) * (ty - yi);
        // crossing strictly right of the test x, direction set by the sign of dy
        if ((dy > 0 && lhs < rhs) || (dy < 0 && lhs > rhs)) begin
          parity = ~parity;
        end
      end
    end
    return parity;
  endfunction

  // check results first, then take in new requests: a result never shares a
  // cycle with an accept, but the order keeps the oldest expectation in front
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (inside_due.size() == 0) begin
          $error("inside_res: result with no query waiting, actual %0b", inside_res_o);
          fail_count++;
        end else begin
          inside_want = inside_due.pop_front();
          if (inside_res_o !== inside_want) begin
            $error("inside_res: expected %0b, actual %0b", inside_want, inside_res_o);
            fail_count++;
          end
        end
      end
      if (cfg_we_i) begin
        poly_count = cfg_wdata_i;
      end
      if (start && !busy) begin
        if (func_i == FuncWrite) begin
          corner_x[slot_i] = coord_x_i;
          corner_y[slot_i] = coord_y_i;
        end else if (answer_given) begin
          inside_due = {inside_due, answer_value};
        end else begin
          inside_due = {inside_due, odd_crossings(coord_x_i, coord_y_i)};
        end
      end
    end
  end

  // one coordinate in the given style
  function automatic coord_t pick_coord(shape_e mode);
    shape_e m;
    m = (mode == ShapeMixed) ? shape_e'($urandom_range(2)) : mode;
    case (m)
      ShapeWide: begin
        return coord_t'($urandom);
      end
      ShapeTight: begin
        return $signed(16'($urandom_range(96))) - 16'sd48;
      end
      default: begin
        case ($urandom_range(3))
          0:       return 16'sh8000;
          1:       return 16'sd32767;
          2:       return 16'sd0;
          default: return -16'sd1;
        endcase
      end
    endcase
  endfunction

  // hand one request over; returns at the edge that accepts it, with start
  // still high so a back-to-back request needs no second assignment
  task automatic send_request(input logic f, input logic [SlotWidth-1:0] s,
                              input coord_t x, input coord_t y,
                              input logic has_answer, input logic answer);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    func_i       <= f;
    slot_i       <= s;
    coord_x_i    <= x;
    coord_y_i    <= y;
    answer_given <= has_answer;
    answer_value <= answer;
    do @(posedge clk_i); while (busy);
    if (f == FuncWrite) begin
      slot_written[s] = 1'b1;
    end
    phase_items++;
  endtask

  task automatic write_corner(input logic [SlotWidth-1:0] s);
    send_request(FuncWrite, s, pick_coord(shape_mode), pick_coord(shape_mode), 1'b0, 1'b0);
  endtask

  // a fresh polygon over every slot the current count walks
  task automatic write_polygon();
    shape_mode = shape_e'($urandom_range(3));
    for (int unsigned k = 0; k < live_corners; k++) begin
      write_corner(SlotWidth'(k));
    end
  endtask

  // a query, with any slot the walk would read written first
  task automatic send_query();
    coord_t qx;
    coord_t qy;
    for (int unsigned k = 0; k < live_corners; k++) begin
      if (!slot_written[k]) begin
        write_corner(SlotWidth'(k));
      end
    end
    // now and then reuse vertex coordinates to hit edge ends and flat edges
    if (live_corners > 0 && $urandom_range(99) < 30) begin
      qx = corner_x[$urandom_range(live_corners - 1)];
      qy = corner_y[$urandom_range(live_corners - 1)];
      if ($urandom_range(1)) begin
        qx = pick_coord(shape_mode);
      end
      // a vertex written at this very edge may not be in the copy yet
      if ($isunknown(qx) || $isunknown(qy)) begin
        qx = pick_coord(shape_mode);
        qy = pick_coord(shape_mode);
      end
    end else begin
      qx = pick_coord(($urandom_range(99) < 70) ? shape_mode : shape_e'($urandom_range(3)));
      qy = pick_coord(($urandom_range(99) < 70) ? shape_mode : shape_e'($urandom_range(3)));
    end
    send_request(FuncQuery, SlotWidth'($urandom), qx, qy, 1'b0, 1'b0);
  endtask

  // wait until every query has answered and the block is idle, then set the count
  task automatic load_count(input logic [CfgWidth-1:0] value);
    start <= 1'b0;
    do @(posedge clk_i); while (inside_due.size() != 0 || busy);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    live_corners = walked_corners(value);
  endtask

  initial begin
    int unsigned pick;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under the reset vertex count
    live_corners = walked_corners(CfgResetCount);
    foreach (directed_rows[r]) begin
      send_request(directed_rows[r].func, directed_rows[r].slot, directed_rows[r].x,
                   directed_rows[r].y, directed_rows[r].has_answer, directed_rows[r].answer);
    end

    // random phases: sender idle chance of 12 percent, then 49, then none
    for (int unsigned p = 0; p < NumPhases; p++) begin
      idle_pct = (p < 4) ? 12 : (p < 8) ? 49 : 0;
      load_count(phase_count[p]);
      phase_items = 0;
      write_polygon();
      while (phase_items < PhaseItems) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          write_polygon();
        end else if (pick < 75) begin
          send_query();
        end else begin
          // stray write to any slot, also the ones the current walk skips
          write_corner(SlotWidth'($urandom));
        end
      end
    end

    start <= 1'b0;
    do @(posedge clk_i); while (inside_due.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[point_in_polygon_test] OK");
    end else begin
      $display("[point_in_polygon_test] ERROR");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("[point_in_polygon_test] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
src/pip_pkg.sv
src/pip_ctrl.sv
src/pip_datapath.sv
src/point_in_polygon_test.sv
bench/testbench.sv
